// ----- rtl/ppd_pkg.sv -----
// Shared types and constants for the preemptive priority dispatcher.
package ppd_pkg;

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 72;
  localparam int M_TUSER_W = 3;

  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_STEP   = 1'b1;

  localparam logic [2:0] EV_STARTED  = 3'd0;
  localparam logic [2:0] EV_RESUMED  = 3'd1;
  localparam logic [2:0] EV_STOPPED  = 3'd2;
  localparam logic [2:0] EV_FINISHED = 3'd3;
  localparam logic [2:0] EV_DROPPED  = 3'd4;

  typedef struct packed {
    logic        valid;
    logic        started;
    logic [7:0]  id;
    logic [3:0]  prio;
    logic [15:0] arrival;
    logic [15:0] run_time;
    logic [15:0] remaining;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic scan_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic has_result;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/ppd_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module ppd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic                            re,
  input  logic [$clog2(DEPTH)-1:0]        raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ppd_ctrl.sv -----
// Dispatcher controller: clearing pass, input accept, store scan and commit sequencing.
module ppd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  ppd_pkg::status_t  status,
  output ppd_pkg::cmd_t     cmd
);

  ppd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppd_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ppd_pkg::ST_CLEAR: begin
        if (status.cnt_last) state_next = ppd_pkg::ST_IDLE;
      end
      ppd_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = ppd_pkg::ST_SCAN;
      end
      ppd_pkg::ST_SCAN: begin
        if (status.cnt_last) state_next = ppd_pkg::ST_TAIL;
      end
      ppd_pkg::ST_TAIL: begin
        state_next = ppd_pkg::ST_DECIDE;
      end
      ppd_pkg::ST_DECIDE: begin
        if (!status.has_result || status.out_free) state_next = ppd_pkg::ST_IDLE;
      end
      default: begin
        state_next = ppd_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ppd_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      ppd_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      ppd_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      ppd_pkg::ST_DECIDE: begin
        cmd.commit = !status.has_result || status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/ppd_datapath.sv -----
// Dispatcher datapath: ready store, scan accumulators, running task, event output register.
module ppd_datapath #(
  parameter int MAX_TASKS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ppd_pkg::cmd_t                   cmd,
  output ppd_pkg::status_t                status,
  input  logic [ppd_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ppd_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [ppd_pkg::M_TUSER_W-1:0]   m_tuser
);

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int EW = $bits(ppd_pkg::entry_t);

  // captured beat
  logic        in_req;
  logic [7:0]  in_id;
  logic [3:0]  in_prio;
  logic [15:0] in_arr;
  logic [15:0] in_run;
  logic [15:0] in_now;
  logic [15:0] in_rep;

  // scan
  logic [AW-1:0] cnt;
  logic          rd_v;
  logic [AW-1:0] rd_idx;
  logic [CW-1:0] count;
  logic          best_found;
  logic [AW-1:0] best_idx;
  ppd_pkg::entry_t best;
  logic          free_found;
  logic [AW-1:0] free_idx;

  // scheduler state
  logic            run_valid;
  ppd_pkg::entry_t run;
  logic [15:0]     last_time;
  logic            last_valid;

  // store port
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  ppd_pkg::entry_t ram_wentry;
  logic [EW-1:0]   ram_rdata;
  ppd_pkg::entry_t rd_entry;

  logic cnt_last;
  assign cnt_last = (cnt == AW'(MAX_TASKS - 1));
  assign rd_entry = ppd_pkg::entry_t'(ram_rdata);

  // decision
  logic          is_step;
  logic [CW:0]   occupancy;
  logic          drop, finish, stop, start, insert, has_result, out_free;
  logic [2:0]    ev_kind;
  logic [7:0]    ev_task;
  logic [15:0]   ev_time;
  logic [15:0]   ev_rem;
  logic [15:0]   ev_wait;
  logic [15:0]   ev_ta;
  ppd_pkg::entry_t ev_entry;
  logic [18:0]   wait_raw;
  logic [16:0]   ta_raw;

  assign is_step   = (in_req == ppd_pkg::REQ_STEP);
  assign occupancy = {1'b0, count} + (CW + 1)'(run_valid);
  assign drop      = !is_step && (occupancy >= (CW + 1)'(MAX_TASKS));
  assign insert    = !is_step && !drop;
  assign finish    = is_step && run_valid && (in_rep == 16'd0);
  assign stop      = is_step && run_valid && (in_rep != 16'd0) && best_found
                     && (best.prio < run.prio);
  assign start     = is_step && !run_valid && best_found
                     && !(last_valid && (last_time == in_now));
  assign has_result = drop || finish || stop || start;
  assign out_free   = !m_tvalid || m_tready;

  always_comb begin
    ev_entry = start ? best : run;
    ev_rem   = start ? best.remaining : (stop ? in_rep : 16'd0);
    if (start) begin
      ev_kind = best.started ? ppd_pkg::EV_RESUMED : ppd_pkg::EV_STARTED;
    end else if (stop) begin
      ev_kind = ppd_pkg::EV_STOPPED;
    end else if (finish) begin
      ev_kind = ppd_pkg::EV_FINISHED;
    end else begin
      ev_kind = ppd_pkg::EV_DROPPED;
    end
    wait_raw = {3'b0, in_now} - {3'b0, ev_entry.arrival} - {3'b0, ev_entry.run_time}
               + {3'b0, ev_rem};
    ta_raw   = {1'b0, in_now} - {1'b0, ev_entry.arrival};
    if (wait_raw[18]) begin
      ev_wait = 16'd0;
    end else if (|wait_raw[17:16]) begin
      ev_wait = 16'hFFFF;
    end else begin
      ev_wait = wait_raw[15:0];
    end
    ev_ta = (finish && !ta_raw[16]) ? ta_raw[15:0] : 16'd0;
    if (drop) begin
      ev_task = in_id;
      ev_time = in_arr;
      ev_rem  = in_run;
      ev_wait = 16'd0;
      ev_ta   = 16'd0;
    end else begin
      ev_task = ev_entry.id;
      ev_time = in_now;
    end
  end

  // store write port
  always_comb begin
    ram_we     = cmd.clear_wr || (cmd.commit && (insert || stop || start));
    ram_waddr  = free_idx;
    ram_wentry = '0;
    if (cmd.clear_wr) begin
      ram_waddr = cnt;
    end else if (start) begin
      ram_waddr = best_idx;
    end else if (insert) begin
      ram_wentry = '{valid: 1'b1, started: 1'b0, id: in_id, prio: in_prio,
                     arrival: in_arr, run_time: in_run, remaining: in_run};
    end else begin
      ram_wentry           = run;
      ram_wentry.valid     = 1'b1;
      ram_wentry.started   = 1'b1;
      ram_wentry.remaining = in_rep;
    end
  end

  ppd_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TASKS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (EW'(ram_wentry)),
    .re    (cmd.scan_rd),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      rd_v       <= 1'b0;
      run_valid  <= 1'b0;
      last_valid <= 1'b0;
      last_time  <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      rd_v <= cmd.scan_rd;
      if (cmd.capture) begin
        cnt <= '0;
      end else if (cmd.clear_wr || cmd.scan_rd) begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end
      if (cmd.commit) begin
        if (finish || stop) begin
          run_valid  <= 1'b0;
          last_valid <= 1'b1;
          last_time  <= in_now;
        end else if (start) begin
          run_valid <= 1'b1;
        end
      end
      if (cmd.commit && has_result) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    if (cmd.capture) begin
      in_req     <= s_tuser;
      in_id      <= s_tdata[7:0];
      in_prio    <= s_tdata[11:8];
      in_arr     <= s_tdata[27:12];
      in_run     <= s_tdata[43:28];
      in_now     <= s_tdata[59:44];
      in_rep     <= s_tdata[75:60];
      count      <= '0;
      best_found <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_v) begin
      if (rd_entry.valid) begin
        count <= count + 1'b1;
        if (!best_found || ({rd_entry.prio, rd_entry.arrival, rd_entry.id}
                            < {best.prio, best.arrival, best.id})) begin
          best_found <= 1'b1;
          best_idx   <= rd_idx;
          best       <= rd_entry;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
    // started flag is forced when the task goes back into the store
    if (cmd.commit && start) begin
      run <= best;
    end
    if (cmd.commit && has_result) begin
      m_tdata <= {ev_ta, ev_wait, ev_rem, ev_time, ev_task};
      m_tuser <= ev_kind;
    end
  end

  assign status.cnt_last   = cnt_last;
  assign status.has_result = has_result;
  assign status.out_free   = out_free;

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (occupancy <= (CW + 1)'(MAX_TASKS)))
    else $error("store plus running task exceed capacity");

  a_free_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (insert || stop)) |-> free_found)
    else $error("store write without a free slot");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && start) |=> (run_valid && m_tvalid))
    else $error("start did not load running task and event");

  a_release: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (finish || stop)) |=> (!run_valid && last_valid))
    else $error("finish or stop did not release running task");

endmodule

// ----- rtl/preemptive_priority_dispatcher.sv -----
// Top level of the preemptive priority dispatcher.
// Each accepted beat passes through an accept state, a scan of every ready-store slot through
// the store's single read port, a tail state for the last read and a decision state that
// writes the store and loads the event register. The decision state is held for as long as
// the beat makes an event and the previous event still waits on the output. The next beat is
// taken while an event still waits on the output. After reset a clearing pass empties the
// store before the first beat is accepted. Arrive beats put a task into the lowest free slot
// or report it dropped; step beats finish, stop, start or resume the running task, ordering
// ready tasks by priority, then arrival, then id, then slot.
module preemptive_priority_dispatcher #(
  parameter int MAX_TASKS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // task_id, task_priority, arrival_time, run_time, step_time, reported_remaining
  input  logic [ppd_pkg::S_TDATA_W-1:0]   s_tdata,
  // req_type
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // event_task, event_time, task_remaining, waiting_time, turnaround_time
  output logic [ppd_pkg::M_TDATA_W-1:0]   m_tdata,
  // event_kind
  output logic [ppd_pkg::M_TUSER_W-1:0]   m_tuser
);

  ppd_pkg::cmd_t    cmd;
  ppd_pkg::status_t status;

  ppd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ppd_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- bench/preemptive_priority_dispatcher_test.sv -----
// Self-checking bench for the preemptive priority dispatcher: directed table, then random traffic.
module preemptive_priority_dispatcher_test;

  localparam int MAX_TASKS   = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int N_DIRECTED  = 24;
  localparam int N_RANDOM    = 1130;

  typedef struct packed {
    logic        req;
    logic [7:0]  id;
    logic [3:0]  prio;
    logic [15:0] arr;
    logic [15:0] run;
    logic [15:0] now;
    logic [15:0] rep;
  } request_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tid;
    logic [15:0] etime;
    logic [15:0] remaining;
    logic [15:0] waiting;
    logic [15:0] turnaround;
  } sched_event_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_EVENT
  } row_check_t;

  typedef struct packed {
    request_t     rq;
    row_check_t   chk;
    sched_event_t want;
  } plan_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [ppd_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                          s_tuser = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [ppd_pkg::M_TDATA_W-1:0] m_tdata;
  logic [ppd_pkg::M_TUSER_W-1:0] m_tuser;

  ppd_pkg::entry_t ready_set [MAX_TASKS];
  ppd_pkg::entry_t run_ent;
  bit              run_ok;
  logic [15:0]     last_t;
  bit              last_ok;
  sched_event_t    pending_events [$];
  int              mismatches = 0;
  int              cycles = 0;
  bit              calm = 1'b0;
  plan_row_t       plan [N_DIRECTED];

  preemptive_priority_dispatcher #(.MAX_TASKS(MAX_TASKS)) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("preemptive_priority_dispatcher_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 27);
  end

  function automatic bit better_than(ppd_pkg::entry_t a, ppd_pkg::entry_t b);
    if (a.prio != b.prio) return a.prio < b.prio;
    if (a.arrival != b.arrival) return a.arrival < b.arrival;
    return a.id < b.id;
  endfunction

  function automatic int best_ready();
    int pick = -1;
    for (int i = 0; i < MAX_TASKS; i++)
      if (ready_set[i].valid && (pick < 0 || better_than(ready_set[i], ready_set[pick])))
        pick = i;
    return pick;
  endfunction

  function automatic sched_event_t make_event(logic [2:0] kind, ppd_pkg::entry_t t,
                                              logic [15:0] now, logic [15:0] rem, bit fin);
    int w;
    int ta;
    sched_event_t e;
    w = int'(now) - int'(t.arrival) - (int'(t.run_time) - int'(rem));
    ta = int'(now) - int'(t.arrival);
    e.kind = kind;
    e.tid = t.id;
    e.etime = now;
    e.remaining = rem;
    e.waiting = (w < 0) ? 16'd0 : (w > 65535) ? 16'hFFFF : 16'(w);
    e.turnaround = (fin && ta > 0) ? 16'(ta) : 16'd0;
    return e;
  endfunction

  // advances the dispatch state by one request, returns the event it causes
  function automatic void dispatch_predict(input request_t rq, output bit has,
                                           output sched_event_t ev);
    int slot;
    int used;
    int pick;
    has = 1'b0;
    ev = '0;
    slot = -1;
    used = run_ok;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (ready_set[i].valid) used++;
      else if (slot < 0) slot = i;
    end
    if (rq.req == ppd_pkg::REQ_ARRIVE) begin
      if (slot < 0 || used >= MAX_TASKS) begin
        has = 1'b1;
        ev = '{ppd_pkg::EV_DROPPED, rq.id, rq.arr, rq.run, 16'd0, 16'd0};
      end else begin
        ready_set[slot] = '{1'b1, 1'b0, rq.id, rq.prio, rq.arr, rq.run, rq.run};
      end
      return;
    end
    if (run_ok) begin
      if (rq.rep == 16'd0) begin
        run_ent.remaining = 16'd0;
        has = 1'b1;
        ev = make_event(ppd_pkg::EV_FINISHED, run_ent, rq.now, 16'd0, 1'b1);
        run_ok = 1'b0;
        last_t = rq.now;
        last_ok = 1'b1;
        return;
      end
      pick = best_ready();
      if (pick >= 0 && ready_set[pick].prio < run_ent.prio) begin
        run_ent.remaining = rq.rep;
        has = 1'b1;
        ev = make_event(ppd_pkg::EV_STOPPED, run_ent, rq.now, rq.rep, 1'b0);
        if (slot >= 0) begin
          ready_set[slot] = run_ent;
          ready_set[slot].valid = 1'b1;
          ready_set[slot].started = 1'b1;
        end
        run_ok = 1'b0;
        last_t = rq.now;
        last_ok = 1'b1;
      end
      return;
    end
    if (last_ok && last_t == rq.now) return;
    pick = best_ready();
    if (pick < 0) return;
    run_ent = ready_set[pick];
    ready_set[pick].valid = 1'b0;
    run_ok = 1'b1;
    has = 1'b1;
    ev = make_event(run_ent.started ? ppd_pkg::EV_RESUMED : ppd_pkg::EV_STARTED, run_ent,
                    rq.now, run_ent.remaining, 1'b0);
    run_ent.started = 1'b1;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    sched_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        $error("event_kind: expected no beat, got kind %0d task %0d", m_tuser, m_tdata[7:0]);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", want.kind, m_tuser);
        check_field("event_task", want.tid, m_tdata[7:0]);
        check_field("event_time", want.etime, m_tdata[23:8]);
        check_field("task_remaining", want.remaining, m_tdata[39:24]);
        check_field("waiting_time", want.waiting, m_tdata[55:40]);
        check_field("turnaround_time", want.turnaround, m_tdata[71:56]);
      end
    end
  end

  task automatic deliver(input request_t rq);
    if (!calm && $urandom_range(0, 99) < 27) begin
      s_tvalid <= 1'b0;
      repeat (($urandom_range(0, 19) == 0) ? $urandom_range(4, 90) : $urandom_range(1, 3))
        @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= rq.req;
    s_tdata <= {4'b0, rq.rep, rq.now, rq.run, rq.arr, rq.prio, rq.id};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  initial begin
    request_t     rq;
    sched_event_t ev;
    bit           has;
    int           burst_left;
    int           r;
    logic [15:0]  tick;

    plan = '{
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd0, 16'd0}, CHK_NONE, '0},
      '{'{ppd_pkg::REQ_ARRIVE, 8'hFF, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_ARRIVE, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd5, 16'd9}, CHK_EVENT,
        '{ppd_pkg::EV_STARTED, 8'h00, 16'd5, 16'd0, 16'd5, 16'd0}},
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd6, 16'd0}, CHK_EVENT,
        '{ppd_pkg::EV_FINISHED, 8'h00, 16'd6, 16'd0, 16'd6, 16'd6}},
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd6, 16'd3}, CHK_NONE, '0},
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd7, 16'd1}, CHK_EVENT,
        '{ppd_pkg::EV_STARTED, 8'hFF, 16'd7, 16'hFFFF, 16'd0, 16'd0}},
      '{'{ppd_pkg::REQ_ARRIVE, 8'h03, 4'h2, 16'd8, 16'd10, 16'd0, 16'd0}, CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_ARRIVE, 8'h02, 4'h2, 16'd8, 16'd10, 16'd0, 16'd0}, CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_ARRIVE, 8'h02, 4'h2, 16'd8, 16'd20, 16'd0, 16'd0}, CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd9, 16'd65000}, CHK_EVENT,
        '{ppd_pkg::EV_STOPPED, 8'hFF, 16'd9, 16'd65000, 16'd0, 16'd0}},
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd9, 16'd4}, CHK_NONE, '0},
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd10, 16'd1}, CHK_EVENT,
        '{ppd_pkg::EV_STARTED, 8'h02, 16'd10, 16'd10, 16'd2, 16'd0}},
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd12, 16'd8}, CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_ARRIVE, 8'h07, 4'h1, 16'd12, 16'd5, 16'd0, 16'd0}, CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd13, 16'd7}, CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd14, 16'd5}, CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd16, 16'd0}, CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd17, 16'd2}, CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_ARRIVE, 8'h55, 4'hA, 16'h00AA, 16'h5555, 16'h5A5A, 16'hA5A5},
        CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_STEP, 8'hAA, 4'h5, 16'hFF55, 16'hAAAA, 16'h8000, 16'd0}, CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_ARRIVE, 8'h40, 4'h0, 16'hFFF0, 16'd3, 16'd0, 16'd0}, CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd20, 16'd9}, CHK_MODEL, '0},
      '{'{ppd_pkg::REQ_STEP, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'd21, 16'd0}, CHK_MODEL, '0}
    };
    foreach (ready_set[i]) ready_set[i] = '0;
    run_ent = '0;
    run_ok = 1'b0;
    last_t = 16'd0;
    last_ok = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      deliver(plan[k].rq);
      dispatch_predict(plan[k].rq, has, ev);
      case (plan[k].chk)
        CHK_MODEL: if (has) pending_events = {pending_events, ev};
        CHK_EVENT: pending_events = {pending_events, plan[k].want};
        default: ;
      endcase
    end
    drain();

    tick = 16'd100;
    burst_left = 70;
    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 150 && n < 400);
      if (n == 580) drain();
      if (n == 600) burst_left = 70;
      rq.id = 8'($urandom_range(0, 255));
      rq.prio = 4'($urandom_range(0, 15));
      rq.now = 16'($urandom);
      rq.rep = 16'($urandom);
      if (burst_left > 0 || $urandom_range(0, 99) < 35) begin
        if (burst_left > 0) burst_left--;
        rq.req = ppd_pkg::REQ_ARRIVE;
        rq.arr = ($urandom_range(0, 99) < 12) ? 16'($urandom)
                                              : tick - 16'($urandom_range(0, 5));
        r = $urandom_range(0, 99);
        rq.run = (r < 5) ? 16'd0 : (r < 20) ? 16'($urandom) : 16'($urandom_range(1, 40));
      end else begin
        rq.req = ppd_pkg::REQ_STEP;
        rq.arr = 16'($urandom);
        rq.run = 16'($urandom);
        tick = tick + 16'($urandom_range(0, 3));
        if ($urandom_range(0, 99) >= 8) rq.now = tick;
        r = $urandom_range(0, 99);
        if (r < 35) rq.rep = 16'd0;
        else if (r < 85) rq.rep = 16'($urandom_range(1, 40));
      end
      deliver(rq);
      dispatch_predict(rq, has, ev);
      if (has) pending_events = {pending_events, ev};
    end
    calm = 1'b0;
    drain();
    repeat (MAX_TASKS + 8) @(posedge clk);

    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("preemptive_priority_dispatcher_test OK");
    end else begin
      $display("preemptive_priority_dispatcher_test NOT OK");
    end
    $finish;
  end

endmodule
